/* design/gale_pkg.sv */
// Shared types, constants and helper functions of the gray array line estimator.
// Used by the lane, divider and top-level modules; depends on nothing else.
package gale_pkg;

  // Sizes of the sensor array and of the fixed result fields.
  localparam int NUM_CH = 8;
  localparam int CH_W = 16;
  localparam int SUM_W = 19;
  localparam int HALF_W = 18;
  localparam int PROD_W = 30;
  localparam int WEIGHT_W = 13;
  localparam int CNT_W = 4;

  // Divider geometry: quotients never exceed 3500, numerators stay below 2^29.
  localparam int DIV_N_W = 29;
  localparam int DIV_D_W = 19;
  localparam int DIV_Q_W = 12;
  localparam int PERM_W = 28;

  // Narrow track: a single run no wider than this many channels.
  localparam logic [CNT_W-1:0] TRACK_MAX_SPAN = 4'd3;
  localparam logic [9:0] PERMILLE = 10'd1000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SIGNAL_THR   = 3'd0;
  localparam logic [2:0] CFG_RELATIVE_THR = 3'd1;
  localparam logic [2:0] CFG_CENTER_OFS   = 3'd2;
  localparam logic [2:0] CFG_WIDE_MIN_ACT = 3'd3;
  localparam logic [2:0] CFG_WIDE_MIN_BG  = 3'd4;
  localparam logic [2:0] CFG_TRACK_MIN_CF = 3'd5;
  localparam logic [2:0] CFG_TRACK_MAX_AC = 3'd6;
  localparam logic [2:0] CFG_MIN_CONF     = 3'd7;

  // Line pattern codes.
  localparam logic [1:0] PAT_NONE   = 2'd0;
  localparam logic [1:0] PAT_WIDE   = 2'd1;
  localparam logic [1:0] PAT_NARROW = 2'd2;
  localparam logic [1:0] PAT_SPLIT  = 2'd3;

  // Frame summary carried down the pipeline, filled in stage by stage.
  typedef struct packed {
    logic                     sv;
    logic [CH_W-1:0]          bg;
    logic [SUM_W-1:0]         sum;
    logic [HALF_W-1:0]        left;
    logic [HALF_W-1:0]        right;
    logic signed [PROD_W-1:0] wsum;
    logic [CNT_W-1:0]         cnt;
    logic [NUM_CH-1:0]        mask;
    logic [SUM_W-1:0]         tsum;
    logic [CNT_W-1:0]         tcnt;
    logic [NUM_CH-1:0]        tmask;
    logic [2:0]               clusters;
    logic [CNT_W-1:0]         span;
    logic [PERM_W-1:0]        perm_num;
    logic signed [PROD_W-1:0] twsum;
  } item_t;

  // Fixed channel weight: -3500 for the leftmost sensor, in steps of 1000.
  function automatic logic signed [WEIGHT_W-1:0] ch_weight(input logic [2:0] lane);
    ch_weight = WEIGHT_W'(signed'({3'd0, lane}) * 13'sd1000 - 13'sd3500);
  endfunction

  // Saturate an unsigned sum to 16 bits.
  function automatic logic [CH_W-1:0] sat_u16(input logic [SUM_W-1:0] v);
    sat_u16 = (v > SUM_W'(16'hFFFF)) ? 16'hFFFF : v[CH_W-1:0];
  endfunction

  // Saturate an 18-bit signed value to 16 bits.
  function automatic logic [CH_W-1:0] sat_s16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      sat_s16 = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      sat_s16 = 16'h8000;
    end else begin
      sat_s16 = v[CH_W-1:0];
    end
  endfunction

endpackage

/* design/gray_array_line_estimator.sv */
// Top level of the gray array line estimator: configuration registers, lanes,
// merging stages, three pipelined dividers and the result register.
// Depends on gale_pkg, gale_lane and gale_div.

// The block takes one eight-channel frame in every clock cycle (busy stays low)
// and gives its result, marked by done, after five stages of lane work and
// merging followed by the twelve-stage dividers for the two centroids and the
// right-hand share. Results cannot be held off: the receiver must take each
// word in the cycle that done is high. The user must write configuration only
// while no frame is in flight; the block itself does not enforce this.
module gray_array_line_estimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] channel_0,
  input  logic [15:0] channel_1,
  input  logic [15:0] channel_2,
  input  logic [15:0] channel_3,
  input  logic [15:0] channel_4,
  input  logic [15:0] channel_5,
  input  logic [15:0] channel_6,
  input  logic [15:0] channel_7,
  input  logic        sample_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data,
  output logic        done,
  output logic        position_valid,
  output logic [15:0] line_position,
  output logic [15:0] line_confidence,
  output logic [7:0]  line_mask,
  output logic [15:0] left_sum,
  output logic [9:0]  right_permille,
  output logic [15:0] background_level,
  output logic [15:0] track_pos,
  output logic [15:0] track_sum,
  output logic [7:0]  track_mask,
  output logic [2:0]  track_clusters,
  output logic [1:0]  line_pattern
);

  localparam int NCH = gale_pkg::NUM_CH;
  localparam int DQ  = gale_pkg::DIV_Q_W;

  // Configuration registers.
  logic [15:0]        signal_threshold;
  logic [15:0]        relative_threshold;
  logic signed [15:0] center_offset;
  logic [3:0]         wide_min_active;
  logic [15:0]        wide_min_background;
  logic [18:0]        track_min_confidence;
  logic [3:0]         track_max_active;
  logic [18:0]        min_confidence;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_threshold     <= '0;
      relative_threshold   <= '0;
      center_offset        <= '0;
      wide_min_active      <= '0;
      wide_min_background  <= '0;
      track_min_confidence <= '0;
      track_max_active     <= 4'd8;
      min_confidence       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gale_pkg::CFG_SIGNAL_THR:   signal_threshold     <= cfg_data[15:0];
        gale_pkg::CFG_RELATIVE_THR: relative_threshold   <= cfg_data[15:0];
        gale_pkg::CFG_CENTER_OFS:   center_offset        <= signed'(cfg_data[15:0]);
        gale_pkg::CFG_WIDE_MIN_ACT: wide_min_active      <= cfg_data[3:0];
        gale_pkg::CFG_WIDE_MIN_BG:  wide_min_background  <= cfg_data[15:0];
        gale_pkg::CFG_TRACK_MIN_CF: track_min_confidence <= cfg_data;
        gale_pkg::CFG_TRACK_MAX_AC: track_max_active     <= cfg_data[3:0];
        gale_pkg::CFG_MIN_CONF:     min_confidence       <= cfg_data;
        default:                    min_confidence       <= min_confidence;
      endcase
    end
  end

  // Input word register.
  logic [15:0] ch_a [NCH];
  logic        va, vb, vc, vd, ve;
  logic        sv_a;
  gale_pkg::item_t b, c, d, e;
  gale_pkg::item_t b_next, c_next, d_next, e_next;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ch_a[0] <= channel_0;
      ch_a[1] <= channel_1;
      ch_a[2] <= channel_2;
      ch_a[3] <= channel_3;
      ch_a[4] <= channel_4;
      ch_a[5] <= channel_5;
      ch_a[6] <= channel_6;
      ch_a[7] <= channel_7;
      sv_a    <= sample_valid;
    end
  end

  // Lanes, one per sensor.
  logic                       act   [NCH];
  logic [15:0]                val_b [NCH];
  logic signed [29:0]         prod  [NCH];
  logic                       tact  [NCH];
  logic [15:0]                rel   [NCH];
  logic signed [29:0]         tprod [NCH];

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    gale_lane u_lane (
      .clk     (clk),
      .lane    (3'(i)),
      .value   (ch_a[i]),
      .sig_thr (signal_threshold),
      .bg      (b.bg),
      .rel_thr (relative_threshold),
      .act     (act[i]),
      .val_b   (val_b[i]),
      .prod    (prod[i]),
      .tact    (tact[i]),
      .rel     (rel[i]),
      .tprod   (tprod[i])
    );
  end

  // Background: the two lowest readings of the frame, averaged.
  always_comb begin
    logic [15:0] lo1;
    logic [15:0] lo2;
    lo1 = 16'hFFFF;
    lo2 = 16'hFFFF;
    for (int i = 0; i < NCH; i++) begin
      if (ch_a[i] < lo1) begin
        lo2 = lo1;
        lo1 = ch_a[i];
      end else if (ch_a[i] < lo2) begin
        lo2 = ch_a[i];
      end
    end
    b_next    = '0;
    b_next.sv = sv_a;
    b_next.bg = 16'((17'(lo1) + 17'(lo2)) >> 1);
  end

  // Merge the absolute lane results.
  always_comb begin
    c_next = b;
    c_next.sum   = '0;
    c_next.left  = '0;
    c_next.right = '0;
    c_next.wsum  = '0;
    c_next.cnt   = '0;
    c_next.mask  = '0;
    for (int i = 0; i < NCH; i++) begin
      if (act[i]) begin
        c_next.sum     = c_next.sum + 19'(val_b[i]);
        c_next.wsum    = c_next.wsum + prod[i];
        c_next.cnt     = c_next.cnt + 4'd1;
        c_next.mask[i] = 1'b1;
        if (i < NCH / 2) begin
          c_next.left = c_next.left + 18'(val_b[i]);
        end else begin
          c_next.right = c_next.right + 18'(val_b[i]);
        end
      end
    end
  end

  // Merge the track lane results: sum, count, runs and span; also the permille numerator.
  always_comb begin
    logic [3:0] first;
    logic [3:0] last;
    d_next = c;
    d_next.tsum     = '0;
    d_next.tcnt     = '0;
    d_next.tmask    = '0;
    d_next.clusters = '0;
    first = '0;
    last  = '0;
    for (int i = 0; i < NCH; i++) begin
      if (tact[i]) begin
        d_next.tsum     = d_next.tsum + 19'(rel[i]);
        d_next.tcnt     = d_next.tcnt + 4'd1;
        d_next.tmask[i] = 1'b1;
        last            = 4'(i);
        if (i == 0 || !tact[i-1]) begin
          d_next.clusters = d_next.clusters + 3'd1;
        end
      end
    end
    for (int i = NCH - 1; i >= 0; i--) begin
      if (tact[i]) begin
        first = 4'(i);
      end
    end
    d_next.span     = (d_next.tcnt == '0) ? 4'd0 : last - first + 4'd1;
    d_next.perm_num = 28'(c.right) * 28'(gale_pkg::PERMILLE);
  end

  // Weighted relative sum.
  always_comb begin
    e_next = d;
    e_next.twsum = '0;
    for (int i = 0; i < NCH; i++) begin
      if (d.tmask[i]) begin
        e_next.twsum = e_next.twsum + tprod[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    b <= b_next;
    c <= c_next;
    d <= d_next;
    e <= e_next;
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      va <= start && !busy;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  // Dividers: line centroid, track centroid and right-hand share.
  logic                  wneg, tneg;
  logic [28:0]           wmag, tmag;
  logic [DQ-1:0]         q_line, q_track, q_perm;

  assign wneg = e.wsum[29];
  assign tneg = e.twsum[29];
  assign wmag = wneg ? 29'(-e.wsum) : e.wsum[28:0];
  assign tmag = tneg ? 29'(-e.twsum) : e.twsum[28:0];

  gale_div u_div_line (
    .clk  (clk),
    .num  (wmag),
    .den  (e.sum),
    .quot (q_line)
  );

  gale_div u_div_track (
    .clk  (clk),
    .num  (tmag),
    .den  (e.tsum),
    .quot (q_track)
  );

  gale_div u_div_perm (
    .clk  (clk),
    .num  (29'(e.perm_num)),
    .den  (e.sum),
    .quot (q_perm)
  );

  // Frame summary delayed alongside the dividers.
  gale_pkg::item_t dly [DQ+1];
  logic            dly_v [DQ+1];

  assign dly[0]   = e;
  assign dly_v[0] = ve;

  always_ff @(posedge clk) begin
    for (int k = 0; k < DQ; k++) begin
      dly[k+1] <= dly[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DQ; k++) begin
        dly_v[k+1] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < DQ; k++) begin
        dly_v[k+1] <= dly_v[k];
      end
    end
  end

  // Final stage: signs, offset, saturation and classification.
  gale_pkg::item_t f;
  logic               f_pvalid;
  logic signed [12:0] c_line, c_track;
  logic signed [17:0] d_line, d_track;
  logic               f_wneg, f_tneg;
  logic [1:0]         pat;

  assign f      = dly[DQ];
  assign f_wneg = f.wsum[29];
  assign f_tneg = f.twsum[29];
  assign c_line  = (f.sum == '0) ? 13'sd0 :
                   (f_wneg ? -signed'({1'b0, q_line}) : signed'({1'b0, q_line}));
  assign c_track = f_tneg ? -signed'({1'b0, q_track}) : signed'({1'b0, q_track});
  assign d_line  = 18'(c_line) - 18'(center_offset);
  assign d_track = 18'(c_track) - 18'(center_offset);
  assign f_pvalid = (f.sum >= min_confidence) && (f.cnt != '0);

  always_comb begin
    priority if (wide_min_active != '0 && f.cnt >= wide_min_active &&
                 f.bg >= wide_min_background) begin
      pat = gale_pkg::PAT_WIDE;
    end else if (f.tsum >= track_min_confidence && f.tcnt != '0 &&
                 f.tcnt <= track_max_active && f.span <= gale_pkg::TRACK_MAX_SPAN &&
                 f.clusters == 3'd1) begin
      pat = gale_pkg::PAT_NARROW;
    end else if (f.tcnt != '0) begin
      pat = gale_pkg::PAT_SPLIT;
    end else begin
      pat = gale_pkg::PAT_NONE;
    end
  end

  // Result word register; an invalid frame gives all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dly_v[DQ];
    end
  end

  always_ff @(posedge clk) begin
    if (f.sv) begin
      position_valid   <= f_pvalid;
      line_position    <= f_pvalid ? gale_pkg::sat_s16(d_line) : '0;
      line_confidence  <= gale_pkg::sat_u16(f.sum);
      line_mask        <= f.mask;
      left_sum         <= gale_pkg::sat_u16(19'(f.left));
      right_permille   <= (f.sum == '0) ? 10'd0 : q_perm[9:0];
      background_level <= f.bg;
      track_pos        <= (f.tsum == '0) ? 16'd0 : gale_pkg::sat_s16(d_track);
      track_sum        <= gale_pkg::sat_u16(f.tsum);
      track_mask       <= f.tmask;
      track_clusters   <= f.clusters;
      line_pattern     <= pat;
    end else begin
      position_valid   <= 1'b0;
      line_position    <= '0;
      line_confidence  <= '0;
      line_mask        <= '0;
      left_sum         <= '0;
      right_permille   <= '0;
      background_level <= '0;
      track_pos        <= '0;
      track_sum        <= '0;
      track_mask       <= '0;
      track_clusters   <= '0;
      line_pattern     <= gale_pkg::PAT_NONE;
    end
  end

endmodule

/* design/gale_lane.sv */
// One sensor lane: threshold test, weighted product, background-relative value.
// Depends on gale_pkg for widths and the channel weight function.
module gale_lane (
  input  logic                               clk,
  input  logic [2:0]                         lane,
  input  logic [gale_pkg::CH_W-1:0]          value,
  input  logic [gale_pkg::CH_W-1:0]          sig_thr,
  input  logic [gale_pkg::CH_W-1:0]          bg,
  input  logic [gale_pkg::CH_W-1:0]          rel_thr,
  output logic                               act,
  output logic [gale_pkg::CH_W-1:0]          val_b,
  output logic signed [gale_pkg::PROD_W-1:0] prod,
  output logic                               tact,
  output logic [gale_pkg::CH_W-1:0]          rel,
  output logic signed [gale_pkg::PROD_W-1:0] tprod
);

  logic signed [gale_pkg::PROD_W-1:0] wx;
  logic signed [gale_pkg::PROD_W-1:0] vx;
  logic signed [gale_pkg::PROD_W-1:0] rx;
  logic [gale_pkg::CH_W-1:0]          rel_next;

  assign wx = gale_pkg::PROD_W'(gale_pkg::ch_weight(lane));
  assign vx = signed'({14'd0, value});
  assign rx = signed'({14'd0, rel});

  // Value above the background, zero where the channel sits at or below it.
  assign rel_next = (val_b > bg) ? val_b - bg : '0;

  // First stage: absolute threshold and weighted reading.
  always_ff @(posedge clk) begin
    val_b <= value;
    act   <= (value >= sig_thr);
    prod  <= vx * wx;
  end

  // Second stage: relative value once the background is known.
  always_ff @(posedge clk) begin
    rel  <= rel_next;
    tact <= (rel_next != '0) && (rel_next >= rel_thr);
  end

  // Third stage: weighted relative value.
  always_ff @(posedge clk) begin
    tprod <= rx * wx;
  end

endmodule

/* design/gale_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on gale_pkg for its widths; quotient must fit DIV_Q_W bits.
module gale_div (
  input  logic                         clk,
  input  logic [gale_pkg::DIV_N_W-1:0] num,
  input  logic [gale_pkg::DIV_D_W-1:0] den,
  output logic [gale_pkg::DIV_Q_W-1:0] quot
);

  localparam int RW = gale_pkg::DIV_N_W + 2;

  logic [gale_pkg::DIV_N_W-1:0] rem [gale_pkg::DIV_Q_W+1];
  logic [gale_pkg::DIV_D_W-1:0] dv  [gale_pkg::DIV_Q_W+1];
  logic [gale_pkg::DIV_Q_W-1:0] qv  [gale_pkg::DIV_Q_W+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qv[0]  = '0;

  // Each stage tries the shifted divisor for one quotient bit, MSB first.
  for (genvar k = 0; k < gale_pkg::DIV_Q_W; k++) begin : g_stage
    localparam int B = gale_pkg::DIV_Q_W - 1 - k;
    logic [RW-1:0]                dsh;
    logic                         fits;
    logic [gale_pkg::DIV_Q_W-1:0] q_next;

    assign dsh  = RW'(dv[k]) << B;
    assign fits = (RW'(rem[k]) >= dsh);

    always_comb begin
      q_next    = qv[k];
      q_next[B] = fits;
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= fits ? gale_pkg::DIV_N_W'(RW'(rem[k]) - dsh) : rem[k];
      dv[k+1]  <= dv[k];
      qv[k+1]  <= q_next;
    end
  end

  assign quot = qv[gale_pkg::DIV_Q_W];

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the gray array line estimator: frames in, one result word per frame.
// Predicts every result with its own centroid model and compares each field.
// Depends on gale_pkg and on the gray_array_line_estimator RTL.

// One sensor frame as presented on the input ports.
typedef struct {
  logic [15:0] ch [8];
  logic        sv;
} frame_t;

// One result word as seen on the output ports.
typedef struct {
  logic        position_valid;
  logic [15:0] line_position;
  logic [15:0] line_confidence;
  logic [7:0]  line_mask;
  logic [15:0] left_sum;
  logic [9:0]  right_permille;
  logic [15:0] background_level;
  logic [15:0] track_pos;
  logic [15:0] track_sum;
  logic [7:0]  track_mask;
  logic [2:0]  track_clusters;
  logic [1:0]  line_pattern;
} estimate_t;

// Centroid predictor with its own register copy and the queue of predicted estimates.
class estimate_board;
  int unsigned sig_thr, rel_thr, wide_act, wide_bg, trk_min_cf, trk_max_act, min_cf;
  int          ofs;
  estimate_t   pending_q [$];
  int          fails;

  function void reset_regs();
    sig_thr = 0; rel_thr = 0; ofs = 0; wide_act = 0; wide_bg = 0;
    trk_min_cf = 0; trk_max_act = 8; min_cf = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [18:0] val);
    case (idx)
      gale_pkg::CFG_SIGNAL_THR:   sig_thr = val[15:0];
      gale_pkg::CFG_RELATIVE_THR: rel_thr = val[15:0];
      gale_pkg::CFG_CENTER_OFS:   ofs = $signed(val[15:0]);
      gale_pkg::CFG_WIDE_MIN_ACT: wide_act = val[3:0];
      gale_pkg::CFG_WIDE_MIN_BG:  wide_bg = val[15:0];
      gale_pkg::CFG_TRACK_MIN_CF: trk_min_cf = val;
      gale_pkg::CFG_TRACK_MAX_AC: trk_max_act = val[3:0];
      gale_pkg::CFG_MIN_CONF:     min_cf = val;
      default: ;
    endcase
  endfunction

  function longint clip_s16(longint v);
    clip_s16 = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function logic [15:0] clip_u16(longint v);
    clip_u16 = (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Works out the estimate of one accepted frame and queues it.
  function void note_frame(frame_t f);
    estimate_t e;
    longint sum, lsum, rsum, wsum, tsum, twsum, lo1, lo2, bg, rel, wt;
    int cnt, tcnt, first, last, runs, span;
    logic [7:0] mask, tmask;
    bit prev, act;
    e = '{default: '0};
    if (f.sv) begin
      sum = 0; lsum = 0; rsum = 0; wsum = 0; cnt = 0; mask = 0;
      lo1 = 65535; lo2 = 65535;
      for (int i = 0; i < 8; i++) begin
        wt = i * 1000 - 3500;
        if (f.ch[i] < lo1) begin
          lo2 = lo1; lo1 = f.ch[i];
        end else if (f.ch[i] < lo2) begin
          lo2 = f.ch[i];
        end
        if (f.ch[i] >= sig_thr) begin
          sum += f.ch[i]; wsum += f.ch[i] * wt; cnt++; mask[i] = 1'b1;
          if (i < 4) lsum += f.ch[i]; else rsum += f.ch[i];
        end
      end
      bg = (lo1 + lo2) / 2;
      // Track channels are those standing clear of the background.
      tsum = 0; twsum = 0; tcnt = 0; tmask = 0; runs = 0; prev = 0; first = 0; last = 0;
      for (int i = 0; i < 8; i++) begin
        rel = (f.ch[i] > bg) ? f.ch[i] - bg : 0;
        act = (rel > 0) && (rel >= rel_thr);
        if (act) begin
          tsum += rel; twsum += rel * (i * 1000 - 3500);
          if (tcnt == 0) first = i;
          last = i; tcnt++; tmask[i] = 1'b1;
          if (!prev) runs++;
        end
        prev = act;
      end
      span = (tcnt == 0) ? 0 : last - first + 1;
      if (tsum > 0) e.track_pos = 16'(clip_s16(twsum / tsum - ofs));
      if (wide_act > 0 && cnt >= wide_act && bg >= wide_bg)
        e.line_pattern = gale_pkg::PAT_WIDE;
      else if (tsum >= trk_min_cf && tcnt > 0 && tcnt <= trk_max_act && span <= 3 && runs == 1)
        e.line_pattern = gale_pkg::PAT_NARROW;
      else if (tcnt > 0)
        e.line_pattern = gale_pkg::PAT_SPLIT;
      else
        e.line_pattern = gale_pkg::PAT_NONE;
      if (sum > 0) e.right_permille = 10'((rsum * 1000) / sum);
      if (sum >= min_cf && cnt > 0) begin
        e.position_valid = 1'b1;
        e.line_position = 16'(clip_s16(((sum > 0) ? wsum / sum : 0) - ofs));
      end
      e.line_confidence = clip_u16(sum);
      e.line_mask = mask;
      e.left_sum = clip_u16(lsum);
      e.background_level = bg[15:0];
      e.track_sum = clip_u16(tsum);
      e.track_mask = tmask;
      e.track_clusters = 3'(runs);
    end
    pending_q.push_back(e);
  endfunction

  function void cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // Compares one result word with the oldest prediction.
  function void check_word(estimate_t r);
    estimate_t e;
    if (pending_q.size() == 0) begin
      $error("result word with no frame outstanding");
      fails++;
      return;
    end
    e = pending_q.pop_front();
    cmp("position_valid", e.position_valid, r.position_valid);
    cmp("line_position", e.line_position, r.line_position);
    cmp("line_confidence", e.line_confidence, r.line_confidence);
    cmp("line_mask", e.line_mask, r.line_mask);
    cmp("left_sum", e.left_sum, r.left_sum);
    cmp("right_permille", e.right_permille, r.right_permille);
    cmp("background_level", e.background_level, r.background_level);
    cmp("track_pos", e.track_pos, r.track_pos);
    cmp("track_sum", e.track_sum, r.track_sum);
    cmp("track_mask", e.track_mask, r.track_mask);
    cmp("track_clusters", e.track_clusters, r.track_clusters);
    cmp("line_pattern", e.line_pattern, r.line_pattern);
  endfunction
endclass

module tb;
  import gale_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] ch [8];
  logic        sample_valid = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;
  logic        done;
  estimate_t   res;
  estimate_board board;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  initial for (int i = 0; i < 8; i++) ch[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gray_array_line_estimator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .channel_0(ch[0]), .channel_1(ch[1]), .channel_2(ch[2]), .channel_3(ch[3]),
    .channel_4(ch[4]), .channel_5(ch[5]), .channel_6(ch[6]), .channel_7(ch[7]),
    .sample_valid(sample_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done),
    .position_valid(res.position_valid), .line_position(res.line_position),
    .line_confidence(res.line_confidence), .line_mask(res.line_mask),
    .left_sum(res.left_sum), .right_permille(res.right_permille),
    .background_level(res.background_level), .track_pos(res.track_pos),
    .track_sum(res.track_sum), .track_mask(res.track_mask),
    .track_clusters(res.track_clusters), .line_pattern(res.line_pattern)
  );

  // Result monitor and watchdog on cycles where no word moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_word(res);
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 4000) begin
        $display("[gray_array_line_estimator] ERROR");
        $finish;
      end
    end
  end

  // Presents one frame, idling first at the current rate, and holds it until taken.
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample_valid <= f.sv;
    for (int i = 0; i < 8; i++) ch[i] <= f.ch[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_frame(f);
  endtask

  // Waits until every predicted word has arrived, with start low.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Holds one register write until it is taken; the caller drops valid afterwards.
  task automatic write_reg(logic [2:0] idx, logic [18:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic write_all(int unsigned sthr, int unsigned rthr, int ofs, int unsigned wact,
                           int unsigned wbg, int unsigned tmin, int unsigned tmax,
                           int unsigned mconf);
    drain();
    write_reg(CFG_SIGNAL_THR, 19'(sthr));
    write_reg(CFG_RELATIVE_THR, 19'(rthr));
    write_reg(CFG_CENTER_OFS, 19'(ofs & 16'hFFFF));
    write_reg(CFG_WIDE_MIN_ACT, 19'(wact));
    write_reg(CFG_WIDE_MIN_BG, 19'(wbg));
    write_reg(CFG_TRACK_MIN_CF, 19'(tmin));
    write_reg(CFG_TRACK_MAX_AC, 19'(tmax));
    write_reg(CFG_MIN_CONF, 19'(mconf));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random register setting, sometimes at the ends of each range but for the two count registers.
  task automatic random_cfg();
    int unsigned v [8];
    v[0] = ($urandom_range(4) == 0) ? 65535 * $urandom_range(1) : $urandom_range(20000);
    v[1] = ($urandom_range(4) == 0) ? 65535 * $urandom_range(1) : $urandom_range(8000);
    v[2] = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 32767 : -32768)
                                    : $signed(16'($urandom_range(65535))) / 8;
    v[3] = $urandom_range(8);
    v[4] = ($urandom_range(4) == 0) ? 65535 * $urandom_range(1) : $urandom_range(10000);
    v[5] = ($urandom_range(4) == 0) ? 524287 * $urandom_range(1) : $urandom_range(60000);
    v[6] = $urandom_range(8);
    v[7] = ($urandom_range(4) == 0) ? 524287 * $urandom_range(1) : $urandom_range(150000);
    write_all(v[0], v[1], int'(v[2]), v[3], v[4], v[5], v[6], v[7]);
  endtask

  // Half the time a low floor with a short bright run; otherwise split, all-or-nothing or raw noise.
  function automatic frame_t make_frame();
    frame_t f;
    int kind, floor_v, pos, width;
    f.sv = ($urandom_range(9) != 0);
    kind = $urandom_range(9);
    floor_v = $urandom_range(3000);
    for (int i = 0; i < 8; i++) f.ch[i] = 16'(floor_v + $urandom_range(300));
    if (kind < 5) begin
      pos = $urandom_range(7);
      width = $urandom_range(1, 4);
      for (int i = pos; i < pos + width && i < 8; i++) f.ch[i] = 16'($urandom_range(20000, 65535));
    end else if (kind == 5) begin
      f.ch[$urandom_range(3)] = 16'($urandom_range(65535));
      f.ch[$urandom_range(4, 7)] = 16'($urandom_range(65535));
    end else if (kind == 6) begin
      for (int i = 0; i < 8; i++) f.ch[i] = 16'($urandom_range(1) ? 16'hFFFF : 16'h0000);
    end else begin
      for (int i = 0; i < 8; i++) f.ch[i] = 16'($urandom_range(65535));
    end
    return f;
  endfunction

  function automatic frame_t flat_frame(logic [15:0] v, logic sv);
    frame_t f;
    f.sv = sv;
    for (int i = 0; i < 8; i++) f.ch[i] = v;
    return f;
  endfunction

  task automatic directed_set();
    frame_t f;
    send_frame(flat_frame(16'h0000, 1'b1));
    send_frame(flat_frame(16'hFFFF, 1'b1));
    send_frame(flat_frame(16'hFFFF, 1'b0));
    send_frame(flat_frame(16'h1234, 1'b1));
    for (int k = 0; k < 8; k += 7) begin
      f = flat_frame(16'd100, 1'b1);
      f.ch[k] = 16'hFFFF;
      send_frame(f);
    end
    f = flat_frame(16'd50, 1'b1);
    f.ch[1] = 16'd40000; f.ch[6] = 16'd40000;
    send_frame(f);
    f = flat_frame(16'd10, 1'b1);
    f.ch[3] = 16'd30000; f.ch[4] = 16'd32000; f.ch[5] = 16'd9000;
    send_frame(f);
    f = flat_frame(16'd0, 1'b1);
    f.ch[0] = 16'hAAAA; f.ch[2] = 16'h5555;
    send_frame(f);
  endtask

  initial begin
    board = new();
    board.reset_regs();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under reset settings, then under two extreme settings and one moderate one.
    directed_set();
    write_all(1000, 0, -32768, 8, 0, 0, 0, 0);
    directed_set();
    write_all(65535, 65535, 32767, 1, 65535, 524287, 8, 524287);
    directed_set();
    write_all(0, 100, 0, 3, 500, 1000, 3, 0);
    directed_set();

    // Random frames over three idling phases, new settings every 50 frames.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 84 : 0;
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0) random_cfg();
        send_frame(make_frame());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.fails == 0) begin
      $display("[gray_array_line_estimator] OK");
    end else begin
      $display("[gray_array_line_estimator] ERROR");
    end
    $finish;
  end
endmodule
